>>> rtl/sssd_pkg.sv
// Package for the sliding SSD block: shared types and constants.
// No dependencies.
package sssd_pkg;

    localparam int LAG_W   = 7;
    localparam int WIN_W   = 9;
    localparam int CH_W    = 3;
    localparam int SSD_W   = 42;
    localparam int LIDX_W  = 6;

    // sample width kept in the stores; samples are sign-extended from it
    localparam int SAMPLE_BITS = 16;

    localparam logic [1:0] CFG_LAG_COUNT     = 2'd0;
    localparam logic [1:0] CFG_WINDOW_FRAMES = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    // Job handed from front to back through the queue
    typedef struct packed {
        logic [LAG_W-1:0] lags;
        logic [WIN_W-1:0] frames;
        logic [CH_W-1:0]  ch;
    } sssd_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } sssd_state_t;

endpackage

>>> rtl/sssd_front.sv
// Front part: accepts sample pairs, writes the stores, issues a job on the last pair.
// Depends on sssd_pkg.
module sssd_front #(
    parameter int ADDR_W = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            sample_a,
    input  logic [15:0]            sample_b,
    input  logic                   last_sample,
    input  sssd_pkg::sssd_job_t    cfg_job,
    input  logic                   busy,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [SAMPLE_BITS-1:0] wr_a,
    output logic [SAMPLE_BITS-1:0] wr_b,
    output logic                   job_valid,
    output sssd_pkg::sssd_job_t    job
);
    import sssd_pkg::*;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              xfer;

    // stall while a job is queued or in work
    assign in_ready = !busy;
    assign xfer     = in_valid && in_ready;
    assign wr_en    = xfer;
    assign wr_addr  = wp_reg;
    assign wr_a     = sample_a[SAMPLE_BITS-1:0];
    assign wr_b     = sample_b[SAMPLE_BITS-1:0];
    assign job_valid = xfer && last_sample;
    assign job      = cfg_job;

    // write pointer, cleared on the last pair
    always_comb
    begin
        wp_next = wp_reg;
        if (xfer)
        begin
            if (last_sample)
                wp_next = '0;
            else
                wp_next = wp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wp_reg <= '0;
        else
            wp_reg <= wp_next;
    end
endmodule

>>> rtl/sssd_queue.sv
// One-entry job queue between front and back.
// Depends on sssd_pkg.
module sssd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sssd_pkg::sssd_job_t push_job,
    input  logic                pop,
    output logic                full,
    output sssd_pkg::sssd_job_t head
);
    import sssd_pkg::*;

    logic      full_reg, full_next;
    sssd_job_t job_reg;

    assign full = full_reg;
    assign head = job_reg;

    always_comb
    begin
        full_next = full_reg;
        if (pop)
            full_next = 1'b0;
        if (push)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            job_reg <= push_job;
    end
endmodule

>>> rtl/sssd_back.sv
// Back part: owns the sample stores; walks each lag one sample per cycle
// and waits for the previous result to be taken. Depends on sssd_pkg.
module sssd_back #(
    parameter int ADDR_W = 10,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LAGS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [SAMPLE_BITS-1:0]     wr_a,
    input  logic [SAMPLE_BITS-1:0]     wr_b,
    input  logic                       job_valid,
    input  sssd_pkg::sssd_job_t        job,
    output logic                       job_pop,
    output logic                       busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [5:0]                 lag_index,
    output logic [41:0]                ssd_a_on_b,
    output logic [41:0]                ssd_b_on_a,
    output logic                       last_result
);
    import sssd_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int SQW   = 2 * SAMPLE_BITS;
    localparam int ACCW  = SSD_W + 1;
    localparam logic [ACCW-1:0] SAT = {1'b0, {SSD_W{1'b1}}};

    logic signed [SAMPLE_BITS-1:0] mem_a [DEPTH];
    logic signed [SAMPLE_BITS-1:0] mem_b [DEPTH];

    sssd_state_t st_reg, st_next;
    logic [LAG_W-1:0]  lags_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [WIN_W+CH_W-1:0] n_reg;
    logic [LAG_W-1:0]  k_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [WIN_W+CH_W-1:0] m_reg;
    logic [ADDR_W-1:0] rm_addr, rf_addr;
    logic signed [SAMPLE_BITS-1:0] am_q, bm_q, af_q, bf_q;
    logic        rd_v_reg, sq_v_reg;
    logic [SQW:0] sq1_reg, sq2_reg;
    logic [ACCW-1:0] acc1_reg, acc2_reg;
    logic signed [DW-1:0] d1, d2;
    logic [DW-1:0] u1, u2;
    logic [ACCW-1:0] s1, s2;
    logic        issue, last_m, lastk;
    logic        out_v_reg;
    logic [5:0]  oidx_reg;
    logic [41:0] o1_reg, o2_reg;
    logic        olast_reg;
    logic [LAG_W-1:0] jl;
    logic [CH_W-1:0]  jc;

    // stores
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
        end
        am_q <= mem_a[rm_addr];
        bm_q <= mem_b[rm_addr];
        af_q <= mem_a[rf_addr];
        bf_q <= mem_b[rf_addr];
    end

    assign rm_addr = off_reg + ADDR_W'(m_reg);
    assign rf_addr = ADDR_W'(m_reg);
    assign issue   = (st_reg == ST_RUN) && (m_reg != n_reg);
    assign last_m  = (m_reg == n_reg);
    assign lastk   = (k_reg + 1'b1 == lags_reg);

    // clamp job parameters
    always_comb
    begin
        jl = job.lags;
        if (jl == '0)
            jl = LAG_W'(1);
        if (jl > LAG_W'(MAX_LAGS))
            jl = LAG_W'(MAX_LAGS);
        jc = (job.ch == '0) ? CH_W'(1) : job.ch;
    end

    // differences, their magnitudes and the saturating accumulator sums
    always_comb
    begin
        d1 = DW'(am_q) - DW'(bf_q);
        d2 = DW'(bm_q) - DW'(af_q);
        u1 = d1[DW-1] ? DW'(-d1) : DW'(d1);
        u2 = d2[DW-1] ? DW'(-d2) : DW'(d2);
        s1 = acc1_reg + ACCW'(sq1_reg);
        s2 = acc2_reg + ACCW'(sq2_reg);
        if (s1 > SAT) s1 = SAT + 1'b1;
        if (s2 > SAT) s2 = SAT + 1'b1;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (job_valid) st_next = ST_RUN;
            ST_RUN:   if (last_m) st_next = ST_DRAIN;
            ST_DRAIN: if (!rd_v_reg && !sq_v_reg) st_next = ST_OUT;
            ST_OUT:   if (!out_v_reg) st_next = lastk ? ST_IDLE : ST_RUN;
            default:  st_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_pop = (st_reg == ST_IDLE) && job_valid;
        busy    = job_valid || (st_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            rd_v_reg  <= 1'b0;
            sq_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            rd_v_reg <= issue;
            sq_v_reg <= rd_v_reg;
            if (out_valid && out_ready)
                out_v_reg <= 1'b0;
            if (st_reg == ST_OUT && !out_v_reg)
                out_v_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sq1_reg <= (SQW+1)'(u1 * u1);
        sq2_reg <= (SQW+1)'(u2 * u2);
        if (issue)
            m_reg <= m_reg + 1'b1;
        if (sq_v_reg)
        begin
            acc1_reg <= s1;
            acc2_reg <= s2;
        end
        case (st_reg)
            ST_IDLE:
            begin
                lags_reg <= jl;
                ch_reg   <= jc;
                n_reg    <= (WIN_W+CH_W)'(job.frames * jc);
                k_reg    <= '0;
                off_reg  <= '0;
                m_reg    <= '0;
                acc1_reg <= '0;
                acc2_reg <= '0;
            end
            ST_OUT:
            begin
                if (!out_v_reg)
                begin
                    oidx_reg  <= k_reg[5:0];
                    o1_reg    <= (acc1_reg > SAT) ? SAT[41:0] : acc1_reg[41:0];
                    o2_reg    <= (acc2_reg > SAT) ? SAT[41:0] : acc2_reg[41:0];
                    olast_reg <= lastk;
                    k_reg     <= k_reg + 1'b1;
                    off_reg   <= off_reg + ADDR_W'(ch_reg);
                    m_reg     <= '0;
                    acc1_reg  <= '0;
                    acc2_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_v_reg;
    assign lag_index   = oidx_reg;
    assign ssd_a_on_b  = o1_reg;
    assign ssd_b_on_a  = o2_reg;
    assign last_result = olast_reg;
endmodule

>>> rtl/sliding_ssd_two_way.sv
// Sliding SSD top level: front loader, job queue and lag engine.
// Depends on sssd_pkg, sssd_front, sssd_queue, sssd_back.
// Loading takes one sample pair per cycle while the input is not stalled. After the
// last pair the engine picks up the job from the queue, then for each lag walks
// window_frames*channel_count samples in the single sample engine (two reads of each
// store per cycle), drains, and waits for the previous result to be taken. Input
// stalls until the engine has produced the last lag; that result may still be waiting at the output.
module sliding_ssd_two_way #(
    parameter int MAX_SAMPLES = 1024,
    parameter int MAX_LAGS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample_a,
    input  logic [15:0] sample_b,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  lag_index,
    output logic [41:0] ssd_a_on_b,
    output logic [41:0] ssd_b_on_a,
    output logic        last_result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import sssd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    sssd_job_t cfg_reg, fjob, qhead;
    logic wr_en, fjv, qfull, qpop, busy;
    logic [ADDR_W-1:0] wr_addr;
    logic [SAMPLE_BITS-1:0] wr_a, wr_b;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lags   <= LAG_W'(10);
            cfg_reg.frames <= WIN_W'(6);
            cfg_reg.ch     <= CH_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAG_COUNT:     cfg_reg.lags   <= cfg_data[LAG_W-1:0];
                CFG_WINDOW_FRAMES: cfg_reg.frames <= cfg_data;
                CFG_CHANNEL_COUNT: cfg_reg.ch     <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    sssd_front #(.ADDR_W(ADDR_W), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .sample_a, .sample_b, .last_sample,
        .cfg_job(cfg_reg), .busy(busy || qfull), .wr_en, .wr_addr, .wr_a, .wr_b,
        .job_valid(fjv), .job(fjob)
    );

    sssd_queue u_queue (
        .clk, .rst_n, .push(fjv), .push_job(fjob), .pop(qpop),
        .full(qfull), .head(qhead)
    );

    sssd_back #(.ADDR_W(ADDR_W), .SAMPLE_BITS(SAMPLE_BITS), .MAX_LAGS(MAX_LAGS)) u_back (
        .clk, .rst_n, .wr_en, .wr_addr, .wr_a, .wr_b,
        .job_valid(qfull), .job(qhead), .job_pop(qpop), .busy,
        .out_valid, .out_ready, .lag_index, .ssd_a_on_b, .ssd_b_on_a, .last_result
    );

    // no load while a job is pending in the queue
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        qfull |-> !in_ready) else $error("load during job");
    // result stays valid and its lag index holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lag_index))
        else $error("result dropped");
    // a job push only when queue empty
    a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fjv |-> !qfull) else $error("queue overrun");
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for sliding_ssd_two_way: loads sample sets and checks the per-lag SSD pairs.
// Depends on sssd_pkg and the sliding_ssd_two_way RTL.
module testbench;
    import sssd_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int LAG_LIMIT   = 64;
    localparam logic [41:0] SSD_SAT = 42'h3FF_FFFF_FFFF;

    typedef struct {
        logic [5:0]  lag;
        logic [41:0] a_on_b;
        logic [41:0] b_on_a;
        logic        last;
    } lag_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] sample_a;
    logic [15:0] sample_b;
    logic        last_sample;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  lag_index;
    logic [41:0] ssd_a_on_b;
    logic [41:0] ssd_b_on_a;
    logic        last_result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    // Predictor state
    logic signed [15:0] mem_a [STORE_DEPTH];
    logic signed [15:0] mem_b [STORE_DEPTH];
    int unsigned        wr_ptr;
    int unsigned        cur_lags;
    int unsigned        cur_frames;
    int unsigned        cur_ch;

    lag_result_t expected_lags[$];
    int          mismatch_count;
    bit          rx_long_stalls;

    sliding_ssd_two_way DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_a(sample_a), .sample_b(sample_b), .last_sample(last_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .lag_index(lag_index), .ssd_a_on_b(ssd_a_on_b), .ssd_b_on_a(ssd_b_on_a),
        .last_result(last_result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #80ms;
        $display("[sliding_ssd_two_way] ERROR");
        $finish;
    end

    // Random gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Exact window sum with modulo read index and saturation
    function automatic logic [41:0] window_sum(bit a_moves, int unsigned offset,
                                               int unsigned n);
        logic [63:0] acc;
        longint      d;
        int unsigned im;
        int unsigned ifx;
        acc = 0;
        for (int unsigned m = 0; m < n; m++)
        begin
            im  = (offset + m) % STORE_DEPTH;
            ifx = m % STORE_DEPTH;
            if (a_moves)
                d = longint'(mem_a[im]) - longint'(mem_b[ifx]);
            else
                d = longint'(mem_b[im]) - longint'(mem_a[ifx]);
            acc += 64'(d * d);
            if (acc > 64'(SSD_SAT))
                acc = 64'(SSD_SAT) + 1;
        end
        return (acc > 64'(SSD_SAT)) ? SSD_SAT : acc[41:0];
    endfunction

    // Predict the effect of one accepted sample pair
    task automatic predict_pair(logic [15:0] a, logic [15:0] b, logic lst);
        int unsigned lags;
        int unsigned ch;
        lag_result_t r;
        mem_a[wr_ptr] = a;
        mem_b[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1 >= STORE_DEPTH) ? 0 : wr_ptr + 1;
        if (!lst)
            return;
        lags = (cur_lags < 1) ? 1 : ((cur_lags > LAG_LIMIT) ? LAG_LIMIT : cur_lags);
        ch = (cur_ch == 0) ? 1 : cur_ch;
        for (int unsigned k = 0; k < lags; k++)
        begin
            r.lag    = 6'(k);
            r.a_on_b = window_sum(1'b1, k * ch, cur_frames * ch);
            r.b_on_a = window_sum(1'b0, k * ch, cur_frames * ch);
            r.last   = (k + 1 == lags);
            expected_lags.push_back(r);
        end
        wr_ptr = 0;
    endtask

    // Send one sample pair, with a random gap ahead of it
    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic lst);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_a    <= a;
        sample_b    <= b;
        last_sample <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        predict_pair(a, b, lst);
    endtask

    // Whole load for the current setting; kind 0 random, 1 max, 2 min, 3 alternating
    task automatic send_set(int kind);
        int unsigned lags;
        int unsigned total;
        logic [15:0] a;
        logic [15:0] b;
        lags = (cur_lags < 1) ? 1 : ((cur_lags > LAG_LIMIT) ? LAG_LIMIT : cur_lags);
        total = (lags + cur_frames) * ((cur_ch == 0) ? 1 : cur_ch);
        for (int unsigned i = 0; i < total; i++)
        begin
            case (kind)
                1: begin a = 16'h7FFF; b = 16'h8000; end
                2: begin a = 16'h8000; b = 16'h7FFF; end
                3: begin a = i[0] ? 16'h8000 : 16'h7FFF; b = ~a; end
                default: begin a = 16'($urandom); b = 16'($urandom); end
            endcase
            send_pair(a, b, i == total - 1);
        end
        in_valid <= 1'b0;
    endtask

    // Idle until all results are in, then allow for engine latency
    task automatic drain();
        int guard;
        guard = 0;
        while (expected_lags.size() != 0 && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 9'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LAG_COUNT:     cur_lags   = val & 7'h7F;
            CFG_WINDOW_FRAMES: cur_frames = val & 9'h1FF;
            default:           cur_ch     = val & 3'h7;
        endcase
    endtask

    task automatic setup(int unsigned lags, int unsigned frames, int unsigned ch);
        write_reg(CFG_LAG_COUNT, lags);
        write_reg(CFG_WINDOW_FRAMES, frames);
        write_reg(CFG_CHANNEL_COUNT, ch);
    endtask

    // Reset-value setting with extreme sample patterns
    task automatic test_reset_config();
        send_set(1);
        send_set(2);
        send_set(3);
        drain();
    endtask

    // Register extremes: single lag, single frame, most lags, 256 frames, four channels
    task automatic test_register_extremes();
        setup(1, 1, 1);
        send_set(0);
        send_set(1);
        drain();
        setup(64, 1, 1);
        send_set(3);
        drain();
        setup(2, 256, 1);
        send_set(0);
        drain();
        setup(3, 2, 4);
        send_set(0);
        drain();
    endtask

    // Random sets, mostly small windows
    task automatic test_random_sets();
        int sent;
        int unsigned frames;
        sent = 0;
        while (sent < 60)
        begin
            frames = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                 : $urandom_range(1, 8);
            setup($urandom_range(1, 12), frames, $urandom_range(1, 4));
            rx_long_stalls = ($urandom_range(0, 3) == 0);
            send_set($urandom_range(0, 7) == 0 ? 3 : 0);
            sent += (cur_lags + cur_frames) * cur_ch;
            drain();
        end
        rx_long_stalls = 1'b0;
    endtask

    // Receiver: random stalls, compare each transfer with oldest expectation
    initial
    begin
        lag_result_t exp_r;
        int st;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_lags.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: lag %0d", lag_index);
                end
                else
                begin
                    exp_r = expected_lags.pop_front();
                    if (lag_index !== exp_r.lag || ssd_a_on_b !== exp_r.a_on_b ||
                        ssd_b_on_a !== exp_r.b_on_a || last_result !== exp_r.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp lag %0d %0d %0d last %0b, got %0d %0d %0d %0b",
                                     exp_r.lag, exp_r.a_on_b, exp_r.b_on_a, exp_r.last,
                                     lag_index, ssd_a_on_b, ssd_b_on_a, last_result);
                    end
                end
            end
            st = $urandom_range(0, 99);
            if (!rx_long_stalls)
                out_ready <= (st < 70);
            else
                out_ready <= (st < 15);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample_a       = '0;
        sample_b       = '0;
        last_sample    = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_LAG_COUNT;
        cfg_data       = '0;
        rx_long_stalls = 1'b0;
        mismatch_count = 0;
        wr_ptr         = 0;
        cur_lags       = 10;
        cur_frames     = 6;
        cur_ch         = 1;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            mem_a[i] = '0;
            mem_b[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_register_extremes();
        test_random_sets();

        if (mismatch_count == 0 && expected_lags.size() == 0)
            $display("[sliding_ssd_two_way] OK");
        else
            $display("[sliding_ssd_two_way] ERROR");
        $finish;
    end
endmodule

>>> files.f
rtl/sssd_pkg.sv
rtl/sssd_front.sv
rtl/sssd_queue.sv
rtl/sssd_back.sv
rtl/sliding_ssd_two_way.sv
tb/sv/testbench.sv
